// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file of the fan curve controller
// no dependencies; take in with a plain include before the module header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define FCP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define FCP_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/fcp_pkg.sv -----
// shared types, constants and helper functions of the fan curve pwm controller
// no dependencies; imported by every module of the block
`default_nettype none

package fcp_pkg;

    // field widths
    localparam int PCT_W  = 7;
    localparam int TEMP_W = 16;

    // duty resolution
    localparam int DUTY_BITS = 10;
    localparam int DUTY_FULL = (1 << DUTY_BITS) - 1;
    localparam logic [DUTY_BITS-1:0] DUTY_FULL_V = DUTY_BITS'(DUTY_FULL);

    // percent limits
    localparam logic [PCT_W-1:0] PCT_FULL       = 7'd100;
    localparam logic [PCT_W-1:0] FIRING_MIN_PCT = 7'd60;

    // interpolation datapath widths
    localparam int SPAN_W = TEMP_W;
    localparam int DVS_W  = SPAN_W + 1;
    localparam int PROD_W = SPAN_W + PCT_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int QUOT_W = PCT_W;

    // divider split over pipeline stages
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = (QUOT_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    // duty = pct*DUTY_A + floor(pct*DUTY_B/100)
    localparam int PA_W = DUTY_BITS + PCT_W;
    localparam logic [DUTY_BITS-1:0] DUTY_A_V = DUTY_BITS'(DUTY_FULL / 100);
    localparam logic [PCT_W-1:0] DUTY_B_V = PCT_W'(DUTY_FULL % 100);
    localparam int Y_W = 2 * PCT_W;

    // floor(y/100) as (y*5243)>>19, exact for y below 43699
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SHIFT = 19;
    localparam int QP_W = Y_W + RECIP_W;

    // register map
    typedef enum logic [2:0] {
        REG_MANUAL_MODE     = 3'd0,
        REG_MANUAL_POWER    = 3'd1,
        REG_AUTO_ENABLE     = 3'd2,
        REG_TEMP_LOW        = 3'd3,
        REG_TEMP_HIGH       = 3'd4,
        REG_POWER_LOW       = 3'd5,
        REG_POWER_HIGH      = 3'd6,
        REG_OUTPUT_INVERTED = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                     manual_mode;
        logic [PCT_W-1:0]         manual_power;
        logic                     auto_enable;
        logic signed [TEMP_W-1:0] temp_low;
        logic signed [TEMP_W-1:0] temp_high;
        logic [PCT_W-1:0]         power_low;
        logic [PCT_W-1:0]         power_high;
        logic                     output_inverted;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        manual_mode:     1'b0,
        manual_power:    7'd0,
        auto_enable:     1'b1,
        temp_low:        16'sd720,
        temp_high:       16'sd4480,
        power_low:       7'd0,
        power_high:      7'd100,
        output_inverted: 1'b0
    };

    // what travels beside the division
    typedef struct packed {
        logic [PCT_W-1:0] base;
        logic             interp;
        logic             min_en;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DVS_W-1:0] dvs;
        side_t            side;
    } div_in_t;

    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [DVS_W-1:0]  dvs;
        logic [QUOT_W-1:0] quot;
        side_t             side;
    } div_work_t;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        side_t             side;
    } div_res_t;

    // low seven bits, saturated at full power
    function automatic logic [PCT_W-1:0] sat_percent(logic [31:0] v);
        return (v[PCT_W-1:0] > PCT_FULL) ? PCT_FULL : v[PCT_W-1:0];
    endfunction

    // one restoring division step for quotient bit k
    function automatic div_work_t div_step(div_work_t w, int k);
        logic [NUM_W-1:0] sh;
        div_work_t        r;
        r = w;
        if (k >= 0)
        begin
            sh = NUM_W'(w.dvs) << k;
            if (w.rem >= sh)
            begin
                r.rem  = w.rem - sh;
                r.quot = w.quot | (QUOT_W'(1) << k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fcp_if.sv -----
// valid/ready channel interfaces for the sample and result beats
// depends on fcp_pkg for field widths
`default_nettype none

interface fcp_in_if import fcp_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;
    logic                     firing;

    modport source (output valid, output temperature, output firing, input ready);
    modport sink   (input valid, input temperature, input firing, output ready);
endinterface

interface fcp_out_if import fcp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [PCT_W-1:0]     power_percent;
    logic [DUTY_BITS-1:0] pwm_duty;

    modport source (output valid, output power_percent, output pwm_duty, input ready);
    modport sink   (input valid, input power_percent, input pwm_duty, output ready);
endinterface

`default_nettype wire

// ----- rtl/fcp_front.sv -----
// front end: curve decode stage and numerator product stage
// depends on fcp_pkg; feeds the pipelined divider
`default_nettype none

module fcp_front import fcp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cfg_t                     cfg,
    input  wire logic                     sample_valid,
    output logic                          sample_ready,
    input  wire logic signed [TEMP_W-1:0] temperature,
    input  wire logic                     firing,
    output logic                          work_valid,
    input  wire logic                     work_ready,
    output div_in_t                       work
);

    logic                     a_valid_reg;
    logic [SPAN_W-1:0]        off_reg;
    logic [SPAN_W-1:0]        span_reg;
    logic [PCT_W-1:0]         diff_reg;
    side_t                    side_reg;
    logic                     b_valid_reg;
    div_in_t                  work_reg;

    logic                     en_a;
    logic                     en_b;
    logic signed [TEMP_W-1:0] t_lo;
    logic signed [TEMP_W-1:0] t_hi;
    logic [PCT_W-1:0]         hi_p;
    logic [TEMP_W:0]          off_wide;
    logic [TEMP_W:0]          span_wide;
    side_t                    side_next;
    logic [PROD_W-1:0]        prod;

    // stall chain
    assign en_b         = !b_valid_reg || work_ready;
    assign en_a         = !a_valid_reg || en_b;
    assign sample_ready = en_a;

    // curve decode
    always_comb
    begin
        t_lo      = cfg.temp_low;
        t_hi      = cfg.temp_high;
        hi_p      = (cfg.power_high < cfg.power_low) ? cfg.power_low : cfg.power_high;
        off_wide  = {temperature[TEMP_W-1], temperature} - {t_lo[TEMP_W-1], t_lo};
        span_wide = {t_hi[TEMP_W-1], t_hi} - {t_lo[TEMP_W-1], t_lo};
        side_next.min_en = firing && !cfg.manual_mode;
        side_next.interp = 1'b0;
        priority if (cfg.manual_mode)
            side_next.base = cfg.manual_power;
        else if (!cfg.auto_enable)
            side_next.base = '0;
        else if (t_hi <= t_lo)
            side_next.base = hi_p;
        else if (temperature <= t_lo)
            side_next.base = cfg.power_low;
        else if (temperature >= t_hi)
            side_next.base = hi_p;
        else
        begin
            side_next.base   = cfg.power_low;
            side_next.interp = 1'b1;
        end
    end

    // numerator 2*off*diff + span, divisor 2*span
    assign prod = PROD_W'(off_reg) * PROD_W'(diff_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_valid_reg <= sample_valid;
            if (en_b)
                b_valid_reg <= a_valid_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en_a && sample_valid)
        begin
            off_reg  <= off_wide[SPAN_W-1:0];
            span_reg <= span_wide[SPAN_W-1:0];
            diff_reg <= hi_p - cfg.power_low;
            side_reg <= side_next;
        end
        if (en_b && a_valid_reg)
        begin
            work_reg.num  <= {prod, 1'b0} + NUM_W'(span_reg);
            work_reg.dvs  <= {span_reg, 1'b0};
            work_reg.side <= side_reg;
        end
    end

    assign work_valid = b_valid_reg;
    assign work       = work_reg;

endmodule

`default_nettype wire

// ----- rtl/fcp_div.sv -----
// pipelined restoring divider, two quotient bits per stage and one in the last
// depends on fcp_pkg (div_step, stage count and widths)
`default_nettype none

module fcp_div import fcp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    work_valid,
    output logic         work_ready,
    input  wire div_in_t work,
    output logic         quot_valid,
    input  wire logic    quot_ready,
    output div_res_t     quot
);

    logic [DIV_STAGES-1:0] valid_reg;
    div_work_t             work_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] stage_en;
    div_work_t             stage_next [DIV_STAGES];

    // stall chain from the last stage back
    always_comb
    begin
        stage_en[DIV_STAGES-1] = !valid_reg[DIV_STAGES-1] || quot_ready;
        for (int s = DIV_STAGES - 2; s >= 0; s--)
            stage_en[s] = !valid_reg[s] || stage_en[s+1];
    end

    assign work_ready = stage_en[0];

    // quotient bits of each stage
    always_comb
    begin
        div_work_t src;
        src.rem  = work.num;
        src.dvs  = work.dvs;
        src.quot = '0;
        src.side = work.side;
        for (int j = 0; j < DIV_STEPS_PER_STAGE; j++)
            src = div_step(src, QUOT_W - 1 - j);
        stage_next[0] = src;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            src = work_reg[s-1];
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++)
                src = div_step(src, QUOT_W - 1 - (s * DIV_STEPS_PER_STAGE + j));
            stage_next[s] = src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (stage_en[0])
                valid_reg[0] <= work_valid;
            for (int s = 1; s < DIV_STAGES; s++)
                if (stage_en[s])
                    valid_reg[s] <= valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0] && work_valid)
            work_reg[0] <= stage_next[0];
        for (int s = 1; s < DIV_STAGES; s++)
            if (stage_en[s] && valid_reg[s-1])
                work_reg[s] <= stage_next[s];
    end

    assign quot_valid = valid_reg[DIV_STAGES-1];
    assign quot.quot  = work_reg[DIV_STAGES-1].quot;
    assign quot.side  = work_reg[DIV_STAGES-1].side;

endmodule

`default_nettype wire

// ----- rtl/fcp_duty.sv -----
// back end: power select, duty products and duty finish with output register
// depends on fcp_pkg for duty constants and the divider result type
`default_nettype none

module fcp_duty import fcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        quot_valid,
    output logic             quot_ready,
    input  wire div_res_t    quot,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [PCT_W-1:0] power_percent,
    output logic [DUTY_BITS-1:0] pwm_duty
);

    logic                 g_valid_reg;
    logic [PCT_W-1:0]     pct_g_reg;
    logic                 h_valid_reg;
    logic [PCT_W-1:0]     pct_h_reg;
    logic [DUTY_BITS-1:0] pa_reg;
    logic [Y_W-1:0]       y_reg;
    logic                 full_reg;
    logic                 i_valid_reg;
    logic [PCT_W-1:0]     pct_out_reg;
    logic [DUTY_BITS-1:0] duty_out_reg;

    logic                 en_g;
    logic                 en_h;
    logic                 en_i;
    logic [PCT_W-1:0]     pct_sum;
    logic [PCT_W-1:0]     pct_next;
    logic [PA_W-1:0]      pa_prod;
    logic [QP_W-1:0]      qp;
    logic [DUTY_BITS-1:0] duty_raw;
    logic [DUTY_BITS-1:0] duty_next;

    // stall chain
    assign en_i       = !i_valid_reg || result_ready;
    assign en_h       = !h_valid_reg || en_i;
    assign en_g       = !g_valid_reg || en_h;
    assign quot_ready = en_g;

    // effective power with the firing minimum
    always_comb
    begin
        pct_sum  = quot.side.base + (quot.side.interp ? quot.quot : '0);
        pct_next = (quot.side.min_en && (pct_sum < FIRING_MIN_PCT)) ? FIRING_MIN_PCT : pct_sum;
    end

    // integer and fractional duty parts
    assign pa_prod = PA_W'(pct_g_reg) * PA_W'(DUTY_A_V);

    // divide by 100 through the reciprocal, full scale and inversion
    always_comb
    begin
        qp        = QP_W'(y_reg) * QP_W'(RECIP_100);
        duty_raw  = full_reg ? DUTY_FULL_V : pa_reg + DUTY_BITS'(qp[RECIP_SHIFT +: PCT_W]);
        duty_next = cfg.output_inverted ? DUTY_FULL_V - duty_raw : duty_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_g)
                g_valid_reg <= quot_valid;
            if (en_h)
                h_valid_reg <= g_valid_reg;
            if (en_i)
                i_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_g && quot_valid)
            pct_g_reg <= pct_next;
        if (en_h && g_valid_reg)
        begin
            pct_h_reg <= pct_g_reg;
            pa_reg    <= pa_prod[DUTY_BITS-1:0];
            y_reg     <= Y_W'(pct_g_reg) * Y_W'(DUTY_B_V);
            full_reg  <= pct_g_reg >= PCT_FULL;
        end
        if (en_i && h_valid_reg)
        begin
            pct_out_reg  <= pct_h_reg;
            duty_out_reg <= duty_next;
        end
    end

    assign result_valid  = i_valid_reg;
    assign power_percent = pct_out_reg;
    assign pwm_duty      = duty_out_reg;

endmodule

`default_nettype wire

// ----- rtl/fan_curve_pwm_controller_unit.sv -----
// Fan curve PWM controller, top level.
// Channels: sample (sink) carries a signed temperature in 1/16 degree C and
// a firing flag; result (source) carries the fan power percent and the PWM
// compare value. Both are valid/ready; a beat moves when valid and ready are
// high at a rising edge. Settings are written through the APB-style port,
// register i at byte address 4*i; the user must write them only while the
// pipeline is empty, which the block itself does not enforce. Throughput:
// one sample per cycle while the result receiver is ready. The stages:
// curve decode, numerator product, four divider stages (two quotient bits
// each, rest in the last), power select, duty products, output register.
// Every stage holds its own valid bit and moves whenever the stage after it
// is empty or moving, so a stalled receiver holds the result in the output
// register while earlier stages keep filling up; sample ready drops only
// once all nine stages are full. Nothing is lost or repeated under stall.
// Reset (rst_n low, asynchronous) empties the pipeline and returns the
// settings to their defaults: curve mode, 45 to 280 degree band, 0 to 100
// percent, duty not inverted.
// depends on fcp_pkg, fcp_if, fcp_front, fcp_div, fcp_duty
`default_nettype none

module fan_curve_pwm_controller_unit import fcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    fcp_in_if.sink           sample,
    fcp_out_if.source        result
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;

    logic     work_valid;
    logic     work_ready;
    div_in_t  work;
    logic     quot_valid;
    logic     quot_ready;
    div_res_t quot;

    // register decode
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    // settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_MANUAL_MODE:     cfg_reg.manual_mode     <= pwdata[0];
                REG_MANUAL_POWER:    cfg_reg.manual_power    <= sat_percent(pwdata);
                REG_AUTO_ENABLE:     cfg_reg.auto_enable     <= pwdata[0];
                REG_TEMP_LOW:        cfg_reg.temp_low        <= pwdata[TEMP_W-1:0];
                REG_TEMP_HIGH:       cfg_reg.temp_high       <= pwdata[TEMP_W-1:0];
                REG_POWER_LOW:       cfg_reg.power_low       <= sat_percent(pwdata);
                REG_POWER_HIGH:      cfg_reg.power_high      <= sat_percent(pwdata);
                REG_OUTPUT_INVERTED: cfg_reg.output_inverted <= pwdata[0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_MANUAL_MODE:     prdata = 32'(cfg_reg.manual_mode);
            REG_MANUAL_POWER:    prdata = 32'(cfg_reg.manual_power);
            REG_AUTO_ENABLE:     prdata = 32'(cfg_reg.auto_enable);
            REG_TEMP_LOW:        prdata = {{(32-TEMP_W){cfg_reg.temp_low[TEMP_W-1]}},
                                           cfg_reg.temp_low};
            REG_TEMP_HIGH:       prdata = {{(32-TEMP_W){cfg_reg.temp_high[TEMP_W-1]}},
                                           cfg_reg.temp_high};
            REG_POWER_LOW:       prdata = 32'(cfg_reg.power_low);
            REG_POWER_HIGH:      prdata = 32'(cfg_reg.power_high);
            REG_OUTPUT_INVERTED: prdata = 32'(cfg_reg.output_inverted);
            default:             prdata = '0;
        endcase
    end

    // curve decode and numerator
    fcp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .temperature  (sample.temperature),
        .firing       (sample.firing),
        .work_valid   (work_valid),
        .work_ready   (work_ready),
        .work         (work)
    );

    // interpolation divider
    fcp_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (work_valid),
        .work_ready (work_ready),
        .work       (work),
        .quot_valid (quot_valid),
        .quot_ready (quot_ready),
        .quot       (quot)
    );

    // power and duty
    fcp_duty u_duty (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .quot_valid    (quot_valid),
        .quot_ready    (quot_ready),
        .quot          (quot),
        .result_valid  (result.valid),
        .result_ready  (result.ready),
        .power_percent (result.power_percent),
        .pwm_duty      (result.pwm_duty)
    );

endmodule

`default_nettype wire

// ----- rtl/fcp_checker.sv -----
// port-level checker for the result channel of the fan curve controller
// depends on fcp_pkg and assert_macros.svh; bound to the top level below
`default_nettype none
`include "assert_macros.svh"

module fcp_checker import fcp_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 valid,
    input wire logic                 ready,
    input wire logic [PCT_W-1:0]     power_percent,
    input wire logic [DUTY_BITS-1:0] pwm_duty
);

    // a stalled result beat stays offered
    `FCP_ASSERT_NEXT(a_result_held, clk, rst_n, valid && !ready, valid, "result beat dropped under stall")

    // power never beyond full scale
    `FCP_ASSERT(a_pct_range, clk, rst_n, valid |-> (power_percent <= PCT_FULL), "power above 100 percent")

    // full power drives the duty to one rail
    `FCP_ASSERT(a_full_rail, clk, rst_n, (valid && power_percent == PCT_FULL) |-> (pwm_duty == DUTY_FULL_V || pwm_duty == '0), "full power not at a duty rail")

    // zero power drives the duty to one rail
    `FCP_ASSERT(a_zero_rail, clk, rst_n, (valid && power_percent == '0) |-> (pwm_duty == DUTY_FULL_V || pwm_duty == '0), "zero power not at a duty rail")

endmodule

bind fan_curve_pwm_controller_unit fcp_checker u_fcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (result.valid),
    .ready         (result.ready),
    .power_percent (result.power_percent),
    .pwm_duty      (result.pwm_duty)
);

`default_nettype wire
